>>> rtl/scsi_wired_or_bus_unit_macros.svh
// ---------------------------------------------------------------------------
// SCSI wired-OR bus unit: assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef SCSI_WIRED_OR_BUS_UNIT_MACROS_SVH
`define SCSI_WIRED_OR_BUS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SWOB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWOB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define SWOB_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWOB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/swob_pkg.sv
// ---------------------------------------------------------------------------
// SCSI wired-OR bus package
// Field widths, access kinds and register map of the bus unit.
// ---------------------------------------------------------------------------
package swob_pkg;

    localparam int DEV_ID_W   = 3;
    localparam int DATA_W     = 8;
    localparam int NOTIFY_W   = 8;
    localparam int CNT_W      = 4;
    localparam int MODE_W     = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // word index of device_count in the register map
    localparam logic [APB_ADDR_W-3:0] REG_DEVICE_COUNT = '0;

    typedef enum logic [MODE_W-1:0] {
        MODE_CTRL  = 2'd0,
        MODE_WATCH = 2'd1,
        MODE_DATA  = 2'd2
    } t_mode;

endpackage

>>> rtl/scsi_wired_or_bus_unit.sv
// Path: each request passes through the input register, then the result register.
// Throughput: one request per cycle while m_axis_tready does not stall the result.
// Reset: synchronous, active low; clears slots, bus ORs, device count and valids.
// ---------------------------------------------------------------------------
// SCSI wired-OR bus unit
// Per-slot control, watch and data registers; control and data are OR-ed onto a
// shared bus, with change and notify reporting on control writes.
// ---------------------------------------------------------------------------
`include "scsi_wired_or_bus_unit_macros.svh"

module scsi_wired_or_bus_unit #(
    parameter int MAX_DEVICES = 8,
    parameter int CTRL_WIDTH  = 9
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // device_id, ctrl_lines, line_mask, data_byte (from bit 0)
    input  logic [((swob_pkg::DEV_ID_W + 2*CTRL_WIDTH + swob_pkg::DATA_W + 7) / 8) * 8 - 1:0]
                                               s_axis_tdata,
    // mode
    input  logic [swob_pkg::MODE_W-1:0]        s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // bus_ctrl, bus_data, changed_lines, notify_devices (from bit 0)
    output logic [((2*CTRL_WIDTH + swob_pkg::DATA_W + swob_pkg::NOTIFY_W + 7) / 8) * 8 - 1:0]
                                               m_axis_tdata,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [swob_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [swob_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [swob_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int CW       = CTRL_WIDTH;
    localparam int OUT_W    = ((2*CW + swob_pkg::DATA_W + swob_pkg::NOTIFY_W + 7) / 8) * 8;
    localparam int OFS_LN   = swob_pkg::DEV_ID_W;
    localparam int OFS_MK   = OFS_LN + CW;
    localparam int OFS_BY   = OFS_MK + CW;
    localparam int NOTIFY_N = (MAX_DEVICES < swob_pkg::NOTIFY_W) ? MAX_DEVICES
                                                                 : swob_pkg::NOTIFY_W;

    // configuration
    logic [swob_pkg::CNT_W-1:0]    r_dev_cnt;
    logic                          cfg_wr;

    // input register
    logic                          r_in_vld;
    swob_pkg::t_mode               r_in_mode;
    logic [swob_pkg::DEV_ID_W-1:0] r_in_id;
    logic [CW-1:0]                 r_in_lines;
    logic [CW-1:0]                 r_in_mask;
    logic [swob_pkg::DATA_W-1:0]   r_in_byte;

    // bus state
    logic [CW-1:0]                 r_slot_ctrl  [MAX_DEVICES];
    logic [CW-1:0]                 r_slot_watch [MAX_DEVICES];
    logic [swob_pkg::DATA_W-1:0]   r_slot_data  [MAX_DEVICES];
    logic [CW-1:0]                 r_comb_ctrl;
    logic [swob_pkg::DATA_W-1:0]   r_comb_data;

    logic [CW-1:0]                 n_slot_ctrl  [MAX_DEVICES];
    logic [CW-1:0]                 n_slot_watch [MAX_DEVICES];
    logic [swob_pkg::DATA_W-1:0]   n_slot_data  [MAX_DEVICES];
    logic [CW-1:0]                 n_comb_ctrl;
    logic [swob_pkg::DATA_W-1:0]   n_comb_data;
    logic [CW-1:0]                 n_changed;
    logic [swob_pkg::NOTIFY_W-1:0] n_notify;

    logic [MAX_DEVICES-1:0]        attached;
    logic [MAX_DEVICES-1:0]        hit;
    logic                          in_range;
    logic [CW-1:0]                 acc_ctrl;
    logic [swob_pkg::DATA_W-1:0]   acc_data;

    // result register
    logic                          r_out_vld;
    logic [CW-1:0]                 r_out_ctrl;
    logic [swob_pkg::DATA_W-1:0]   r_out_data;
    logic [CW-1:0]                 r_out_changed;
    logic [swob_pkg::NOTIFY_W-1:0] r_out_notify;

    logic                          advance;
    logic                          in_take;

    // ---- configuration port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                 && (paddr[swob_pkg::APB_ADDR_W-1:2] == swob_pkg::REG_DEVICE_COUNT);

    always_comb begin
        prdata = '0;
        if (paddr[swob_pkg::APB_ADDR_W-1:2] == swob_pkg::REG_DEVICE_COUNT) begin
            prdata = swob_pkg::APB_DATA_W'(r_dev_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_cnt <= '0;
        end else if (cfg_wr) begin
            r_dev_cnt <= pwdata[swob_pkg::CNT_W-1:0];
        end
    end

    // ---- handshake ----
    assign advance       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode  <= swob_pkg::t_mode'(s_axis_tuser);
            r_in_id    <= s_axis_tdata[swob_pkg::DEV_ID_W-1:0];
            r_in_lines <= s_axis_tdata[OFS_LN +: CW];
            r_in_mask  <= s_axis_tdata[OFS_MK +: CW];
            r_in_byte  <= s_axis_tdata[OFS_BY +: swob_pkg::DATA_W];
        end
    end

    // ---- request evaluation ----
    always_comb begin
        for (int i = 0; i < MAX_DEVICES; i++) begin
            attached[i] = 32'(r_dev_cnt) > i;
            hit[i]      = attached[i] && (32'(r_in_id) == i);
        end
        in_range = 32'(r_in_id) < MAX_DEVICES;
    end

    always_comb begin
        n_slot_ctrl  = r_slot_ctrl;
        n_slot_watch = r_slot_watch;
        n_slot_data  = r_slot_data;
        n_comb_ctrl  = r_comb_ctrl;
        n_comb_data  = r_comb_data;
        n_changed    = '0;
        n_notify     = '0;
        acc_ctrl     = '0;
        acc_data     = '0;
        case (r_in_mode)
            swob_pkg::MODE_CTRL: begin
                if (in_range) begin
                    for (int i = 0; i < MAX_DEVICES; i++) begin
                        if (hit[i]) begin
                            n_slot_ctrl[i] = (r_slot_ctrl[i] & ~r_in_mask)
                                           | (r_in_lines & r_in_mask);
                        end
                        if (attached[i]) begin
                            acc_ctrl = acc_ctrl | n_slot_ctrl[i];
                        end
                    end
                    n_changed   = r_comb_ctrl ^ acc_ctrl;
                    n_comb_ctrl = acc_ctrl;
                    for (int i = 0; i < NOTIFY_N; i++) begin
                        if (attached[i] && (32'(r_in_id) != i)
                            && ((r_slot_watch[i] & n_changed) != '0)) begin
                            n_notify[i] = 1'b1;
                        end
                    end
                end
            end
            swob_pkg::MODE_WATCH: begin
                for (int i = 0; i < MAX_DEVICES; i++) begin
                    if (hit[i]) begin
                        n_slot_watch[i] = (r_slot_watch[i] & ~r_in_mask)
                                        | (r_in_lines & r_in_mask);
                    end
                end
            end
            swob_pkg::MODE_DATA: begin
                if (|hit) begin
                    for (int i = 0; i < MAX_DEVICES; i++) begin
                        if (hit[i]) begin
                            n_slot_data[i] = r_in_byte;
                        end
                        if (attached[i]) begin
                            acc_data = acc_data | n_slot_data[i];
                        end
                    end
                    n_comb_data = acc_data;
                end
            end
            default: begin
            end
        endcase
    end

    // ---- state and result update ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DEVICES; i++) begin
                r_slot_ctrl[i]  <= '0;
                r_slot_watch[i] <= '0;
                r_slot_data[i]  <= '0;
            end
            r_comb_ctrl <= '0;
            r_comb_data <= '0;
            r_out_vld   <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_slot_ctrl  <= n_slot_ctrl;
                r_slot_watch <= n_slot_watch;
                r_slot_data  <= n_slot_data;
                r_comb_ctrl  <= n_comb_ctrl;
                r_comb_data  <= n_comb_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_out_ctrl    <= n_comb_ctrl;
            r_out_data    <= n_comb_data;
            r_out_changed <= n_changed;
            r_out_notify  <= n_notify;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_W'({r_out_notify, r_out_changed, r_out_data, r_out_ctrl});

    // ---- assertions ----
    `SWOB_ASSERT_IMPL(a_notify_needs_change, i_clk, i_rst_n,
        r_out_vld && (r_out_changed == '0), r_out_notify == '0,
        "notify raised without a changed line")
    `SWOB_ASSERT_IMPL(a_bus_ctrl_tracks_state, i_clk, i_rst_n,
        r_out_vld, r_out_ctrl == r_comb_ctrl,
        "result bus_ctrl differs from stored bus OR")
    `SWOB_ASSERT_IMPL(a_stall_means_full, i_clk, i_rst_n,
        !s_axis_tready, r_in_vld && r_out_vld,
        "input stalled while a stage is empty")
    `SWOB_ASSERT(a_changed_is_toggle, i_clk, i_rst_n,
        (advance && r_in_vld) |=> (r_out_changed == (r_comb_ctrl ^ $past(r_comb_ctrl))),
        "changed lines disagree with bus OR toggle")

endmodule

>>> sim/scsi_wired_or_bus_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SCSI wired-OR bus checker
// Watches the request, result and register ports of the bus unit. It keeps
// its own model of the slot registers and bus ORs, queues the expected result
// of every accepted request, and compares each result in order, field by field.
// ---------------------------------------------------------------------------
module scsi_wired_or_bus_checker #(
    parameter int MAX_DEV = 8,
    parameter int CTRL_W  = 9,
    parameter int REQ_W   = 32,
    parameter int RES_W   = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  logic                              i_req_ready,
    input  logic [REQ_W-1:0]                  i_req_data,
    input  logic [swob_pkg::MODE_W-1:0]       i_req_user,
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    input  logic [RES_W-1:0]                  i_res_data,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic                              i_pready,
    input  logic [swob_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  logic [swob_pkg::APB_DATA_W-1:0]   i_pwdata,
    output int unsigned                       o_fail_count,
    output int unsigned                       o_pending
);

    localparam int DATA_W   = swob_pkg::DATA_W;
    localparam int NOTIFY_W = swob_pkg::NOTIFY_W;
    localparam int ID_W     = swob_pkg::DEV_ID_W;

    typedef struct {
        logic [CTRL_W-1:0]   bus_ctrl;
        logic [DATA_W-1:0]   bus_data;
        logic [CTRL_W-1:0]   changed_lines;
        logic [NOTIFY_W-1:0] notify_devices;
    } t_bus_result;

    logic [CTRL_W-1:0]          slot_lines [MAX_DEV];
    logic [CTRL_W-1:0]          slot_watch [MAX_DEV];
    logic [DATA_W-1:0]          slot_byte  [MAX_DEV];
    logic [CTRL_W-1:0]          bus_lines;
    logic [DATA_W-1:0]          bus_byte;
    logic [swob_pkg::CNT_W-1:0] dev_count;

    t_bus_result expected_results [$];
    int unsigned mismatches;

    initial begin
        mismatches = 0;
    end

    function automatic t_bus_result predict_bus_access(
        logic [swob_pkg::MODE_W-1:0] mode,
        logic [ID_W-1:0]             id,
        logic [CTRL_W-1:0]           lines,
        logic [CTRL_W-1:0]           mask,
        logic [DATA_W-1:0]           byte_in
    );
        t_bus_result       r;
        int                active;
        logic              attached;
        logic [CTRL_W-1:0] ctrl_or;
        logic [DATA_W-1:0] data_or;
        active   = (dev_count > MAX_DEV) ? MAX_DEV : int'(dev_count);
        attached = int'(id) < active;
        r.changed_lines  = '0;
        r.notify_devices = '0;
        if (int'(id) < MAX_DEV) begin
            if (mode == swob_pkg::MODE_CTRL) begin
                if (attached) begin
                    slot_lines[id] = (slot_lines[id] & ~mask) | (lines & mask);
                end
                ctrl_or = '0;
                for (int i = 0; i < active; i++) begin
                    ctrl_or |= slot_lines[i];
                end
                r.changed_lines = bus_lines ^ ctrl_or;
                bus_lines = ctrl_or;
                // writer never hears about its own change
                for (int i = 0; i < active && i < NOTIFY_W; i++) begin
                    if (i != int'(id) && |(slot_watch[i] & r.changed_lines)) begin
                        r.notify_devices[i] = 1'b1;
                    end
                end
            end else if (mode == swob_pkg::MODE_WATCH) begin
                if (attached) begin
                    slot_watch[id] = (slot_watch[id] & ~mask) | (lines & mask);
                end
            end else if (mode == swob_pkg::MODE_DATA) begin
                if (attached) begin
                    slot_byte[id] = byte_in;
                    data_or = '0;
                    for (int i = 0; i < active; i++) begin
                        data_or |= slot_byte[i];
                    end
                    bus_byte = data_or;
                end
            end
        end
        r.bus_ctrl = bus_lines;
        r.bus_data = bus_byte;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_bus_result got;
        t_bus_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_DEV; i++) begin
                slot_lines[i] = '0;
                slot_watch[i] = '0;
                slot_byte[i]  = '0;
            end
            bus_lines = '0;
            bus_byte  = '0;
            dev_count = '0;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[swob_pkg::APB_ADDR_W-1:2] == swob_pkg::REG_DEVICE_COUNT) begin
                dev_count = i_pwdata[swob_pkg::CNT_W-1:0];
            end
            if (i_res_valid && i_res_ready) begin
                got.bus_ctrl       = i_res_data[CTRL_W-1:0];
                got.bus_data       = i_res_data[CTRL_W +: DATA_W];
                got.changed_lines  = i_res_data[CTRL_W+DATA_W +: CTRL_W];
                got.notify_devices = i_res_data[2*CTRL_W+DATA_W +: NOTIFY_W];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("checker: unexpected result %h at %0t", i_res_data, $time);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.bus_ctrl !== want.bus_ctrl ||
                        got.bus_data !== want.bus_data ||
                        got.changed_lines !== want.changed_lines ||
                        got.notify_devices !== want.notify_devices) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("checker: mismatch at %0t ctrl/data/changed/notify", $time);
                            $display("  expected %h %h %h %h", want.bus_ctrl, want.bus_data,
                                     want.changed_lines, want.notify_devices);
                            $display("  actual   %h %h %h %h", got.bus_ctrl, got.bus_data,
                                     got.changed_lines, got.notify_devices);
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                expected_results.push_back(predict_bus_access(
                    i_req_user,
                    i_req_data[ID_W-1:0],
                    i_req_data[ID_W +: CTRL_W],
                    i_req_data[ID_W+CTRL_W +: CTRL_W],
                    i_req_data[ID_W+2*CTRL_W +: DATA_W]));
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SCSI wired-OR bus unit testbench
// Drives bus access requests in bursts against a stalling result sink,
// steps the device count through empty, partial, full and over-capacity
// settings between phases, and takes the verdict from the checker.
// ---------------------------------------------------------------------------
module tb;

    localparam int MAX_DEV     = 8;
    localparam int CTRL_W      = 9;
    localparam int ID_W        = swob_pkg::DEV_ID_W;
    localparam int DATA_W      = swob_pkg::DATA_W;
    localparam int MODE_W      = swob_pkg::MODE_W;
    localparam int CNT_W       = swob_pkg::CNT_W;
    localparam int ADDR_W      = swob_pkg::APB_ADDR_W;
    localparam int PDATA_W     = swob_pkg::APB_DATA_W;
    localparam int REQ_W       = ((ID_W + 2*CTRL_W + DATA_W + 7) / 8) * 8;
    localparam int RES_W       = ((2*CTRL_W + DATA_W + swob_pkg::NOTIFY_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 63;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [CTRL_W-1:0] LINES_ALL   = '1;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic [REQ_W-1:0]      req_data  = '0;
    logic [MODE_W-1:0]     req_mode  = swob_pkg::MODE_CTRL;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    logic [RES_W-1:0]      res_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [ADDR_W-1:0]     paddr     = '0;
    logic [PDATA_W-1:0]    pwdata    = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;
    int unsigned stall_cycle = 0;
    int unsigned burst_left  = 0;

    scsi_wired_or_bus_unit #(
        .MAX_DEVICES (MAX_DEV),
        .CTRL_WIDTH  (CTRL_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (req_valid),
        .s_axis_tready (req_ready),
        .s_axis_tdata  (req_data),
        .s_axis_tuser  (req_mode),
        .m_axis_tvalid (res_valid),
        .m_axis_tready (res_ready),
        .m_axis_tdata  (res_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    scsi_wired_or_bus_checker #(
        .MAX_DEV (MAX_DEV),
        .CTRL_W  (CTRL_W),
        .REQ_W   (REQ_W),
        .RES_W   (RES_W)
    ) bus_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req_data   (req_data),
        .i_req_user   (req_mode),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res_data   (res_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // result sink: always ready, coin toss, mostly stalled, periodic
    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle / 97) % 4)
            0: begin
                res_ready <= 1'b1;
            end
            1: begin
                res_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                res_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                res_ready <= (stall_cycle % 3 != 0);
            end
        endcase
    end

    task automatic send_access(
        logic [MODE_W-1:0]   mode,
        logic [ID_W-1:0]     id,
        logic [CTRL_W-1:0]   lines,
        logic [CTRL_W-1:0]   mask,
        logic [DATA_W-1:0]   byte_in
    );
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_valid <= 1'b1;
        req_mode  <= mode;
        req_data  <= REQ_W'({byte_in, mask, lines, id});
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
    endtask

    task automatic random_access(int unsigned active);
        int unsigned          pick;
        logic [MODE_W-1:0]    mode;
        logic [ID_W-1:0]      id;
        logic [CTRL_W-1:0]    lines;
        logic [CTRL_W-1:0]    mask;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            mode = swob_pkg::MODE_CTRL;
        end else if (pick < 70) begin
            mode = swob_pkg::MODE_WATCH;
        end else if (pick < 92) begin
            mode = swob_pkg::MODE_DATA;
        end else begin
            mode = MODE_UNUSED;
        end
        if (active > 0 && $urandom_range(0, 3) != 0) begin
            id = ID_W'($urandom_range(0, ((active > MAX_DEV) ? MAX_DEV : active) - 1));
        end else begin
            id = ID_W'($urandom_range(0, MAX_DEV - 1));
        end
        case ($urandom_range(0, 7))
            0: lines = '0;
            1: lines = LINES_ALL;
            default: lines = CTRL_W'($urandom_range(0, 511));
        endcase
        case ($urandom_range(0, 7))
            0: mask = '0;
            1, 2: mask = LINES_ALL;
            default: mask = CTRL_W'($urandom_range(0, 511));
        endcase
        send_access(mode, id, lines, mask, DATA_W'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_device_count(logic [CNT_W-1:0] count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {swob_pkg::REG_DEVICE_COUNT, 2'b00};
        pwdata  <= PDATA_W'(count);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned counts [10];
        counts = '{8, 1, 15, 4, 0, 9, 2, 7, 8, 6};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing attached: control write re-ORs to zero, data write ignored
        send_access(swob_pkg::MODE_CTRL, 3'd0, LINES_ALL, LINES_ALL, 8'hFF);
        send_access(swob_pkg::MODE_DATA, 3'd0, '0, '0, 8'hFF);
        send_access(swob_pkg::MODE_WATCH, 3'd0, LINES_ALL, LINES_ALL, 8'h00);
        wait_drained();

        write_device_count(4'd8);
        send_access(swob_pkg::MODE_WATCH, 3'd0, LINES_ALL, LINES_ALL, 8'h00);
        send_access(swob_pkg::MODE_WATCH, 3'd1, 9'h001, 9'h001, 8'h00);
        send_access(swob_pkg::MODE_WATCH, 3'd7, 9'h100, LINES_ALL, 8'h00);
        // writer with full watch mask must not see its own change
        send_access(swob_pkg::MODE_CTRL, 3'd0, LINES_ALL, LINES_ALL, 8'h00);
        send_access(swob_pkg::MODE_CTRL, 3'd7, 9'h100, 9'h100, 8'h00);
        send_access(swob_pkg::MODE_CTRL, 3'd0, '0, LINES_ALL, 8'h00);
        send_access(swob_pkg::MODE_CTRL, 3'd3, LINES_ALL, '0, 8'h00);
        send_access(swob_pkg::MODE_DATA, 3'd7, '0, '0, 8'hFF);
        send_access(swob_pkg::MODE_DATA, 3'd0, '0, '0, 8'h00);
        send_access(swob_pkg::MODE_DATA, 3'd3, '0, '0, 8'h5A);
        send_access(MODE_UNUSED, 3'd2, LINES_ALL, LINES_ALL, 8'hFF);
        send_access(swob_pkg::MODE_WATCH, 3'd7, '0, 9'h0FF, 8'h00);
        wait_drained();

        // shrinking the count keeps stale ORs until the next write
        write_device_count(4'd3);
        send_access(swob_pkg::MODE_CTRL, 3'd7, '0, '0, 8'h00);
        send_access(swob_pkg::MODE_DATA, 3'd1, '0, '0, 8'h81);
        send_access(swob_pkg::MODE_WATCH, 3'd5, LINES_ALL, LINES_ALL, 8'h00);
        send_access(swob_pkg::MODE_DATA, 3'd6, '0, '0, 8'h3C);
        wait_drained();

        write_device_count(4'd15);
        send_access(swob_pkg::MODE_CTRL, 3'd7, 9'h0AA, LINES_ALL, 8'h00);
        send_access(swob_pkg::MODE_DATA, 3'd7, '0, '0, 8'h00);
        send_access(swob_pkg::MODE_CTRL, 3'd2, 9'h155, 9'h1F0, 8'h00);
        wait_drained();

        foreach (counts[p]) begin
            write_device_count(CNT_W'(counts[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_access(counts[p]);
                if (p == 3 && n == 30) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/swob_pkg.sv
rtl/scsi_wired_or_bus_unit.sv
sim/scsi_wired_or_bus_checker.sv
sim/tb.sv
